>>> src/ncwg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncwg_pkg
// Shared types and constants for the neighbour community weight gather.
// ----------------------------------------------------------------------------
package ncwg_pkg;

    localparam int ID_W     = 10;
    localparam int WEIGHT_W = 32;
    localparam int ID_SPACE = 1 << ID_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EDGE  = 1'b1;

    localparam logic [WEIGHT_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [WEIGHT_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic                       operation;
        logic [ID_W-1:0]            centre_node;
        logic [ID_W-1:0]            neighbour_node;
        logic [ID_W-1:0]            community_id;
        logic signed [WEIGHT_W-1:0] edge_weight;
        logic                       last_edge;
    } in_beat_t;

    typedef struct packed {
        logic [ID_W-1:0]            neighbour_community;
        logic signed [WEIGHT_W-1:0] community_weight;
        logic                       last_result;
    } out_beat_t;

    typedef struct packed {
        logic clr;
        logic load;
        logic memb_wr;
        logic memb_rd;
        logic acc_rd_edge;
        logic acc_upd;
        logic list_rd;
        logic acc_rd_emit;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_edge;
        logic is_last;
        logic list_empty;
        logic emit_last;
    } sts_t;

endpackage

>>> src/ncwg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncwg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ncwg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/ncwg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncwg_ctrl
// Sequencer: clearing sweep, membership writes, edge read-modify-write and
// the closing walk over the touched list.
// ----------------------------------------------------------------------------
module ncwg_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    output ncwg_pkg::cmd_t cmd,
    input  ncwg_pkg::sts_t sts
);
    import ncwg_pkg::*;

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b00_0000_0001,
        ST_IDLE  = 10'b00_0000_0010,
        ST_WRITE = 10'b00_0000_0100,
        ST_MRD   = 10'b00_0000_1000,
        ST_ARD   = 10'b00_0001_0000,
        ST_AWR   = 10'b00_0010_0000,
        ST_EMIT  = 10'b00_0100_0000,
        ST_LRD   = 10'b00_1000_0000,
        ST_LACC  = 10'b01_0000_0000,
        ST_OUT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // operation comes straight from the input beat while idle
    function automatic logic start_is_edge(input sts_t s, input logic go);
        start_is_edge = s.is_edge & go;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (start_is_edge(sts, start)) ? ST_MRD : ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.memb_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_MRD:
            begin
                cmd.memb_rd = 1'b1;
                state_next  = ST_ARD;
            end
            ST_ARD:
            begin
                cmd.acc_rd_edge = 1'b1;
                state_next      = ST_AWR;
            end
            ST_AWR:
            begin
                cmd.acc_upd = 1'b1;
                state_next  = sts.is_last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                state_next = sts.list_empty ? ST_IDLE : ST_LRD;
            end
            ST_LRD:
            begin
                cmd.list_rd = 1'b1;
                state_next  = ST_LACC;
            end
            ST_LACC:
            begin
                cmd.acc_rd_emit = 1'b1;
                state_next      = ST_OUT;
            end
            ST_OUT:
            begin
                cmd.emit   = 1'b1;
                state_next = sts.emit_last ? ST_IDLE : ST_LRD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

>>> src/ncwg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncwg_dp
// Datapath: membership RAM, accumulator RAM with listed flag, touched list,
// saturating add and the emit index.
// ----------------------------------------------------------------------------
module ncwg_dp #(
    parameter int NODE_COUNT      = 1024,
    parameter int COMMUNITY_COUNT = 1024,
    parameter int MAX_TOUCHED     = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ncwg_pkg::in_beat_t  item,
    input  ncwg_pkg::cmd_t      cmd,
    output ncwg_pkg::sts_t      sts,
    output ncwg_pkg::out_beat_t result
);
    import ncwg_pkg::*;

    localparam int ND    = (NODE_COUNT < ID_SPACE) ? NODE_COUNT : ID_SPACE;
    localparam int CD    = (COMMUNITY_COUNT < ID_SPACE) ? COMMUNITY_COUNT : ID_SPACE;
    localparam int MAXD  = (ND > CD) ? ND : CD;
    localparam int NA_W  = $clog2(ND);
    localparam int CA_W  = $clog2(CD);
    localparam int CL_W  = $clog2(MAXD);
    localparam int CNT_W = $clog2(MAX_TOUCHED + 1);
    localparam int LA_W  = (MAX_TOUCHED > 1) ? $clog2(MAX_TOUCHED) : 1;
    localparam int ACC_W = WEIGHT_W + 1;

    localparam logic [ID_W:0]  ND_L   = (ID_W + 1)'(ND);
    localparam logic [ID_W:0]  CD_L   = (ID_W + 1)'(CD);
    localparam logic [CL_W-1:0] CL_END = CL_W'(MAXD - 1);

    in_beat_t          item_reg;
    logic [CL_W-1:0]   clr_ctr_reg;
    logic [CL_W-1:0]   clr_ctr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [LA_W-1:0]   idx_reg;
    logic [LA_W-1:0]   idx_next;
    logic [ID_W-1:0]   comm_reg;

    logic              m_we;
    logic [NA_W-1:0]   m_waddr;
    logic [ID_W-1:0]   m_wdata;
    logic [ID_W-1:0]   m_rdata;

    logic              a_we;
    logic [CA_W-1:0]   a_waddr;
    logic [ACC_W-1:0]  a_wdata;
    logic              a_re;
    logic [CA_W-1:0]   a_raddr;
    logic [ACC_W-1:0]  a_rdata;

    logic              l_we;
    logic [ID_W-1:0]   l_rdata;

    logic              neigh_ok;
    logic              write_ok;
    logic [ID_W-1:0]   comm_edge;
    logic [WEIGHT_W-1:0] w_eff;
    logic [WEIGHT_W-1:0] acc_old;
    logic              listed;
    logic [ACC_W-1:0]  sum;
    logic [WEIGHT_W-1:0] sum_sat;
    logic              add_new;
    logic              emit_last;

    assign neigh_ok = ({1'b0, item_reg.neighbour_node} < ND_L);
    assign write_ok = ({1'b0, item_reg.centre_node} < ND_L)
                   && ({1'b0, item_reg.community_id} < CD_L);
    assign comm_edge = neigh_ok ? m_rdata : '0;

    assign w_eff = (item_reg.neighbour_node == item_reg.centre_node)
                 ? {item_reg.edge_weight[WEIGHT_W-1], item_reg.edge_weight[WEIGHT_W-1:1]}
                 : item_reg.edge_weight;
    assign acc_old = a_rdata[WEIGHT_W-1:0];
    assign listed  = a_rdata[WEIGHT_W];
    assign sum     = {acc_old[WEIGHT_W-1], acc_old} + {w_eff[WEIGHT_W-1], w_eff};

    always_comb
    begin
        case (sum[WEIGHT_W:WEIGHT_W-1])
            2'b01:   sum_sat = SAT_MAX;
            2'b10:   sum_sat = SAT_MIN;
            default: sum_sat = sum[WEIGHT_W-1:0];
        endcase
    end

    assign add_new = !listed && (sum != '0) && (count_reg < CNT_W'(MAX_TOUCHED));
    assign emit_last = (({1'b0, idx_reg} + (LA_W + 1)'(1)) == (LA_W + 1)'(count_reg));

    // membership RAM ports
    always_comb
    begin
        if (cmd.clr)
        begin
            m_we    = (32'(clr_ctr_reg) < 32'(ND));
            m_waddr = clr_ctr_reg[NA_W-1:0];
            m_wdata = '0;
        end
        else
        begin
            m_we    = cmd.memb_wr && write_ok;
            m_waddr = item_reg.centre_node[NA_W-1:0];
            m_wdata = item_reg.community_id;
        end
    end

    // accumulator RAM ports: {listed, sum}
    always_comb
    begin
        a_we    = 1'b0;
        a_waddr = comm_reg[CA_W-1:0];
        a_wdata = '0;
        if (cmd.clr)
        begin
            a_we    = (32'(clr_ctr_reg) < 32'(CD));
            a_waddr = clr_ctr_reg[CA_W-1:0];
        end
        else if (cmd.acc_upd)
        begin
            a_we    = listed || add_new;
            a_wdata = {1'b1, sum_sat};
        end
        else if (cmd.emit)
        begin
            a_we = 1'b1;
        end
    end

    assign a_re    = cmd.acc_rd_edge || cmd.acc_rd_emit;
    assign a_raddr = cmd.acc_rd_emit ? l_rdata[CA_W-1:0] : comm_edge[CA_W-1:0];
    assign l_we    = cmd.acc_upd && add_new;

    always_comb
    begin
        clr_ctr_next = clr_ctr_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        if (cmd.clr && clr_ctr_reg != CL_END)
        begin
            clr_ctr_next = clr_ctr_reg + CL_W'(1);
        end
        if (l_we)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.emit)
        begin
            if (emit_last)
            begin
                idx_next   = '0;
                count_next = '0;
            end
            else
            begin
                idx_next = idx_reg + LA_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ctr_reg <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            clr_ctr_reg <= clr_ctr_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.acc_rd_edge)
        begin
            comm_reg <= comm_edge;
        end
        else if (cmd.acc_rd_emit)
        begin
            comm_reg <= l_rdata;
        end
    end

    ncwg_ram #(
        .WIDTH (ID_W),
        .DEPTH (ND)
    ) u_memb_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .re    (cmd.memb_rd),
        .raddr (item_reg.neighbour_node[NA_W-1:0]),
        .rdata (m_rdata)
    );

    ncwg_ram #(
        .WIDTH (ACC_W),
        .DEPTH (CD)
    ) u_acc_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .re    (a_re),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    ncwg_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_TOUCHED)
    ) u_list_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (count_reg[LA_W-1:0]),
        .wdata (comm_reg),
        .re    (cmd.list_rd),
        .raddr (idx_reg),
        .rdata (l_rdata)
    );

    assign sts.clear_done = (clr_ctr_reg == CL_END);
    assign sts.is_edge    = (item.operation == OP_EDGE);
    assign sts.is_last    = item_reg.last_edge;
    assign sts.list_empty = (count_reg == '0);
    assign sts.emit_last  = emit_last;

    assign result.neighbour_community = comm_reg;
    assign result.community_weight    = acc_old;
    assign result.last_result         = emit_last;

endmodule

>>> src/neighbour_community_weight_gather.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbour_community_weight_gather
// Node-to-community lookup with per-community saturating weight sums,
// listed once per run and emitted on the last edge.
// ----------------------------------------------------------------------------
// Membership write: a single RAM write. Edge: membership read, then accumulator
// read-modify-write. Last edge adds an EMIT state, then per touched community
// a list read, an accumulator read and one result beat.
// After reset, busy stays high while both memories are swept to zero over
// max(NODE_COUNT, COMMUNITY_COUNT) addresses (capped at 1024).
// One item at a time; results cannot be stalled.
module neighbour_community_weight_gather #(
    parameter int NODE_COUNT      = 1024,
    parameter int COMMUNITY_COUNT = 1024,
    parameter int MAX_TOUCHED     = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ncwg_pkg::in_beat_t  item,
    output logic                result_valid,
    output ncwg_pkg::out_beat_t result
);
    import ncwg_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ncwg_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    ncwg_dp #(
        .NODE_COUNT      (NODE_COUNT),
        .COMMUNITY_COUNT (COMMUNITY_COUNT),
        .MAX_TOUCHED     (MAX_TOUCHED)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

    assign result_valid = cmd.emit;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks neighbour_community_weight_gather against an in-bench prediction of
// the membership table, the per-community saturating sums and the touched
// list. Directed beats cover self loops, saturation, listing rules, empty runs
// and mid-run membership writes; random runs of edges with random content
// and noise beats follow under several sender idle rates.
// ----------------------------------------------------------------------------
module testbench;

    import ncwg_pkg::*;

    localparam int     MAX_TOUCHED = 32;
    localparam longint Q_MAX       = 64'sd2147483647;
    localparam longint Q_MIN       = -64'sd2147483648;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_beat_t  item;
    logic      result_valid;
    out_beat_t result;

    logic [ID_W-1:0]            community_of [ID_SPACE];
    logic signed [WEIGHT_W-1:0] weight_sum [ID_SPACE];
    logic [ID_W-1:0]            touched_communities [$];
    out_beat_t                  expected_sums [$];

    int mismatch_count;
    int sender_idle_pct;

    neighbour_community_weight_gather dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic signed [WEIGHT_W-1:0] saturate_q16(input longint v);
        if (v > Q_MAX)
            return SAT_MAX;
        else if (v < Q_MIN)
            return SAT_MIN;
        else
            return v[WEIGHT_W-1:0];
    endfunction

    task automatic predict_community_sums(input in_beat_t b);
        logic [ID_W-1:0]            comm;
        logic signed [WEIGHT_W-1:0] w;
        longint                     sum;
        bit                         listed;
        out_beat_t                  r;
        int                         n;
        if (b.operation == OP_WRITE)
        begin
            community_of[b.centre_node] = b.community_id;
        end
        else
        begin
            comm = community_of[b.neighbour_node];
            w    = b.edge_weight;
            if (b.neighbour_node == b.centre_node)
                w = w >>> 1;
            listed = 1'b0;
            foreach (touched_communities[i])
                if (touched_communities[i] == comm)
                    listed = 1'b1;
            sum = longint'(weight_sum[comm]) + longint'(w);
            if (listed)
            begin
                weight_sum[comm] = saturate_q16(sum);
            end
            else if (sum != 0 && touched_communities.size() < MAX_TOUCHED)
            begin
                weight_sum[comm] = saturate_q16(sum);
                touched_communities.insert(touched_communities.size(), comm);
            end
            if (b.last_edge)
            begin
                n = touched_communities.size();
                for (int i = 0; i < n; i++)
                begin
                    r.neighbour_community = touched_communities[i];
                    r.community_weight    = weight_sum[touched_communities[i]];
                    r.last_result         = (i == n - 1);
                    expected_sums.insert(expected_sums.size(), r);
                    weight_sum[touched_communities[i]] = '0;
                end
                touched_communities.delete();
            end
        end
    endtask

    // accepted input beats
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            predict_community_sums(item);
    end

    // result beats
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && result_valid)
        begin
            if (expected_sums.size() == 0)
            begin
                $error("unexpected result: community %0d weight %0d last %0d",
                       result.neighbour_community, result.community_weight,
                       result.last_result);
                mismatch_count++;
            end
            else
            begin
                want = expected_sums.pop_front();
                if (result.neighbour_community !== want.neighbour_community)
                begin
                    $error("neighbour_community: expected %0d, got %0d",
                           want.neighbour_community, result.neighbour_community);
                    mismatch_count++;
                end
                if (result.community_weight !== want.community_weight)
                begin
                    $error("community_weight: expected %0d, got %0d",
                           want.community_weight, result.community_weight);
                    mismatch_count++;
                end
                if (result.last_result !== want.last_result)
                begin
                    $error("last_result: expected %0d, got %0d",
                           want.last_result, result.last_result);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic in_beat_t make_beat(input logic op, input int centre, input int neigh,
                                           input int cid, input logic [WEIGHT_W-1:0] w,
                                           input logic last);
        in_beat_t b;
        b.operation      = op;
        b.centre_node    = centre[ID_W-1:0];
        b.neighbour_node = neigh[ID_W-1:0];
        b.community_id   = cid[ID_W-1:0];
        b.edge_weight    = w;
        b.last_edge      = last;
        return b;
    endfunction

    function automatic int pick_node();
        if ($urandom_range(99) < 70)
            return $urandom_range(0, 95);
        else
            return $urandom_range(0, ID_SPACE - 1);
    endfunction

    function automatic int pick_community();
        if ($urandom_range(99) < 60)
            return $urandom_range(0, 63);
        else
            return $urandom_range(0, ID_SPACE - 1);
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        logic [WEIGHT_W-1:0] mag;
        case ($urandom_range(9))
            0: return '0;
            1: return SAT_MAX;
            2: return SAT_MIN;
            3: return $urandom_range(1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
            8, 9: return $urandom;
            default:
            begin
                mag = $urandom_range(0, 32'h000F_FFFF);
                return $urandom_range(1) ? mag : -mag;
            end
        endcase
    endfunction

    task automatic send_beat(input in_beat_t b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= b;
        do @(posedge clk); while (busy);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge clk); while (expected_sums.size() != 0);
    endtask

    task automatic test_membership_writes();
        send_beat(make_beat(OP_WRITE, 5, 77, 1023, 32'h1234_5678, 1'b1));
        send_beat(make_beat(OP_WRITE, 1023, 1023, 7, SAT_MIN, 1'b0));
        send_beat(make_beat(OP_WRITE, 9, 0, 3, SAT_MAX, 1'b1));
    endtask

    task automatic test_run_extremes();
        send_beat(make_beat(OP_EDGE, 5, 5, 0, 32'hFFFF_FFFD, 1'b0));  // self loop, -3 -> -2
        send_beat(make_beat(OP_EDGE, 5, 1023, 1023, SAT_MAX, 1'b0));
        send_beat(make_beat(OP_EDGE, 5, 1023, 0, SAT_MAX, 1'b0));     // clamps high
        send_beat(make_beat(OP_EDGE, 5, 0, 511, '0, 1'b0));           // zero add lists nothing
        send_beat(make_beat(OP_EDGE, 5, 9, 0, 32'd100, 1'b0));
        send_beat(make_beat(OP_EDGE, 5, 9, 0, -32'sd100, 1'b0));      // back to zero, stays listed
        send_beat(make_beat(OP_WRITE, 9, 512, 4, 32'h0F0F_0F0F, 1'b0));
        send_beat(make_beat(OP_EDGE, 5, 9, 0, SAT_MIN, 1'b0));
        send_beat(make_beat(OP_EDGE, 5, 9, 0, 32'hFFFF_FFFF, 1'b0));  // clamps low
        send_beat(make_beat(OP_EDGE, 1023, 1023, 0, SAT_MIN, 1'b1));
    endtask

    task automatic test_empty_run_and_rounding();
        send_beat(make_beat(OP_EDGE, 3, 0, 0, '0, 1'b1));             // nothing to emit
        send_beat(make_beat(OP_EDGE, 0, 0, 0, 32'h0000_0001, 1'b0));  // 1 halves to 0
        send_beat(make_beat(OP_EDGE, 0, 0, 0, 32'hFFFF_FFFF, 1'b1));  // -1 halves to -1
    endtask

    task automatic test_random_traffic(input int beats, input int idle_pct);
        int              sent;
        int              run_len;
        int              centre;
        int              neigh;
        bit              paused;
        in_beat_t        b;
        logic [63:0]     noise;
        sender_idle_pct = idle_pct;
        sent   = 0;
        paused = 1'b0;
        while (sent < beats)
        begin
            if (!paused && sent >= beats / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            repeat ($urandom_range(0, 4))
            begin
                send_beat(make_beat(OP_WRITE, pick_node(), pick_node(), pick_community(),
                                    pick_weight(), 1'($urandom_range(1))));
                sent++;
            end
            run_len = ($urandom_range(99) < 15) ? $urandom_range(30, 45) : $urandom_range(1, 10);
            centre  = pick_node();
            for (int k = 0; k < run_len; k++)
            begin
                if ($urandom_range(99) < 8)
                begin
                    noise = {$urandom, $urandom};
                    b     = noise;
                end
                else
                begin
                    neigh = ($urandom_range(99) < 15) ? centre : pick_node();
                    b = make_beat(OP_EDGE, centre, neigh, $urandom_range(0, ID_SPACE - 1),
                                  pick_weight(), k == run_len - 1);
                end
                send_beat(b);
                sent++;
            end
        end
    endtask

    initial
    begin
        foreach (community_of[i])
        begin
            community_of[i] = '0;
            weight_sum[i]   = '0;
        end
        mismatch_count  = 0;
        sender_idle_pct = 7;
        start <= 1'b0;
        item  <= '0;
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_membership_writes();
        test_run_extremes();
        test_empty_run_and_rounding();
        test_random_traffic(170, 7);
        test_random_traffic(170, 82);
        test_random_traffic(170, 0);

        wait_drained();
        repeat (150) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
